>>> sv/hct_pkg.sv
package hct_pkg;

	// Fixed field widths of one request and one result.
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned SYMBOL_W = 8;
	localparam int unsigned LEN_W    = 5;
	localparam int unsigned CODE_W   = 16;
	localparam int unsigned STATUS_W = 2;

	// The running code needs one bit more than the longest code.
	localparam int unsigned NEXT_W = CODE_W + 1;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_LOOKUP = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_ORDER = 2'd2
	} status_t;

endpackage

>>> sv/hct_in_if.sv
interface hct_in_if;
	import hct_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [SYMBOL_W-1:0] symbol;
	logic [LEN_W-1:0]    code_length;

	modport source (output valid, output req_type, output symbol, output code_length,
		input ready);
	modport sink (input valid, input req_type, input symbol, input code_length,
		output ready);
endinterface

>>> sv/hct_out_if.sv
interface hct_out_if;
	import hct_pkg::*;

	logic                valid;
	logic                ready;
	logic [CODE_W-1:0]   code;
	logic [LEN_W-1:0]    code_bits;
	logic                found;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output code, output code_bits, output found,
		output status, input ready);
	modport sink (input valid, input code, input code_bits, input found,
		input status, output ready);
endinterface

>>> sv/hct_ram.sv
module hct_ram #(
	parameter int unsigned WIDTH = 21,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/canonical_huffman_code_table_core.sv
// Canonical Huffman code table for JPEG. Symbols are appended in table order, each with
// its code length in nondecreasing order; the block hands each one the running canonical
// code (the previous code plus one, shifted up by any growth in length) and stores it.
// A symbol whose code no longer fits in its length is dropped with status "full", and a
// length that is zero, too long, or shorter than the previous one is refused with status
// "order error" and leaves the table untouched. A repeated symbol still consumes a code,
// but its first entry is kept. Lookups return the stored code and length, or all zeros
// when the symbol is absent. A clear request empties the table at once, since
// the per-symbol valid marks are flip-flops; no clearing pass follows reset. Every
// transaction of any kind produces exactly one result transaction. The block accepts one
// transaction per clock while the output is not stalled. The code and length of each
// symbol sit in one RAM with a registered read, which stage 1 waits on, and each
// result then passes an output register that parts the two channels. Appends
// write the RAM at the cycle they are accepted and lookups read it at the cycle they are
// accepted, so a lookup right after an append of the same symbol already sees the new
// entry and no forwarding is needed. A stalled output holds the RAM read data by gating
// its read enable with the input handshake.
module canonical_huffman_code_table_core #(
	parameter int unsigned SYMBOL_COUNT    = 256,
	parameter int unsigned MAX_CODE_LENGTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	hct_in_if.sink    in_ch,
	hct_out_if.source out_ch
);
	import hct_pkg::*;

	localparam int unsigned IDX_W   = $clog2(SYMBOL_COUNT);
	localparam int unsigned ENTRY_W = CODE_W + LEN_W;

	// Table state kept in flip-flops: valid marks and the code generator.
	logic [SYMBOL_COUNT-1:0] valid_q;
	logic [NEXT_W-1:0]       next_code_q;
	logic [LEN_W-1:0]        cur_len_q;

	// Stage 1 holds the result of the accepted transaction while the RAM read completes.
	logic                s1_valid;
	logic                s1_lookup;
	logic                s1_hit;
	logic [CODE_W-1:0]   s1_code;
	logic [LEN_W-1:0]    s1_bits;
	logic                s1_found;
	status_t             s1_status;

	// Output register.
	logic                out_valid_q;
	logic [CODE_W-1:0]   code_q;
	logic [LEN_W-1:0]    bits_q;
	logic                found_q;
	status_t             status_q;

	logic                accept;
	logic                s1_adv;
	req_t                req;
	logic [IDX_W-1:0]    idx;
	logic                in_range;
	logic                len_err;
	logic [LEN_W-1:0]    len_diff;
	logic [NEXT_W-1:0]   shifted;
	logic [NEXT_W-1:0]   limit;
	logic                space_full;
	logic                store;
	logic [ENTRY_W-1:0]  rd_entry;

	assign s1_adv       = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !s1_valid || s1_adv;
	assign accept       = in_ch.valid && in_ch.ready;
	assign req          = req_t'(in_ch.req_type);

	assign in_range = {1'b0, in_ch.symbol} < (SYMBOL_W+1)'(SYMBOL_COUNT);
	assign idx      = in_ch.symbol[IDX_W-1:0];

	// Appended length must lie in range and never fall below the previous one.
	assign len_err = (in_ch.code_length == '0)
		|| (in_ch.code_length > LEN_W'(MAX_CODE_LENGTH))
		|| (in_ch.code_length < cur_len_q);
	assign len_diff   = in_ch.code_length - cur_len_q;
	assign shifted    = next_code_q << len_diff;
	assign limit      = NEXT_W'(1) << in_ch.code_length;
	assign space_full = shifted >= limit;

	// A fitting append stores only a symbol that is in range and not yet present.
	assign store = accept && (req == REQ_APPEND) && !len_err && !space_full
		&& in_range && !valid_q[idx];

	hct_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SYMBOL_COUNT)
	) u_entry_ram (
		.clk  (clk),
		.we   (store),
		.waddr(idx),
		.wdata({shifted[CODE_W-1:0], in_ch.code_length}),
		.re   (accept && (req == REQ_LOOKUP)),
		.raddr(idx),
		.rdata(rd_entry)
	);

	// Code generator and valid marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			next_code_q <= '0;
			cur_len_q   <= '0;
		end else if (accept) begin
			unique case (req)
				REQ_CLEAR: begin
					valid_q     <= '0;
					next_code_q <= '0;
					cur_len_q   <= '0;
				end
				REQ_APPEND: begin
					if (!len_err) begin
						cur_len_q <= in_ch.code_length;
						if (space_full) begin
							next_code_q <= limit;
						end else begin
							next_code_q <= shifted + NEXT_W'(1);
						end
						if (store) begin
							valid_q[idx] <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 1: results of clear, append and unused requests are final here; a lookup
	// only records whether it hits and takes its data from the registered RAM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (req)
				REQ_APPEND: begin
					s1_lookup <= 1'b0;
					s1_hit    <= 1'b0;
					if (len_err) begin
						s1_code   <= '0;
						s1_bits   <= '0;
						s1_found  <= 1'b0;
						s1_status <= STATUS_ORDER;
					end else if (space_full) begin
						s1_code   <= '0;
						s1_bits   <= '0;
						s1_found  <= 1'b0;
						s1_status <= STATUS_FULL;
					end else begin
						s1_code   <= shifted[CODE_W-1:0];
						s1_bits   <= in_ch.code_length;
						s1_found  <= store;
						s1_status <= STATUS_OK;
					end
				end
				REQ_LOOKUP: begin
					s1_lookup <= 1'b1;
					s1_hit    <= in_range && valid_q[idx];
					s1_code   <= '0;
					s1_bits   <= '0;
					s1_found  <= 1'b0;
					s1_status <= STATUS_OK;
				end
				default: begin
					s1_lookup <= 1'b0;
					s1_hit    <= 1'b0;
					s1_code   <= '0;
					s1_bits   <= '0;
					s1_found  <= 1'b0;
					s1_status <= STATUS_OK;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			status_q <= s1_status;
			if (s1_lookup) begin
				code_q  <= s1_hit ? rd_entry[ENTRY_W-1:LEN_W] : '0;
				bits_q  <= s1_hit ? rd_entry[LEN_W-1:0] : '0;
				found_q <= s1_hit;
			end else begin
				code_q  <= s1_code;
				bits_q  <= s1_bits;
				found_q <= s1_found;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.code      = code_q;
	assign out_ch.code_bits = bits_q;
	assign out_ch.found     = found_q;
	assign out_ch.status    = status_q;

	// The running code never passes the size of the code space at the current length.
	a_next_code_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_code_q <= (NEXT_W'(1) << cur_len_q))
		else $error("running code exceeds code space");

	// A clear leaves an empty table and a restarted code generator.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req == REQ_CLEAR) |=> (valid_q == '0) && (next_code_q == '0)
			&& (cur_len_q == '0))
		else $error("clear did not empty the table");

	// A refused or dropped append carries no code.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != STATUS_OK) |-> (code_q == '0) && (bits_q == '0)
			&& !found_q)
		else $error("error result carries a code");

	// A stored append or a lookup hit always has a nonzero length.
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> (bits_q != '0) && (status_q == STATUS_OK))
		else $error("found result without length");

endmodule

>>> tb/sv/testbench.sv
module testbench;
	import hct_pkg::*;

	// Block configuration under test; the predictor uses the same bounds.
	localparam int unsigned TABLE_SYMBOLS = 256;
	localparam int unsigned MAX_LEN       = 16;

	// Request type 3 is not defined by the package; the block must ignore it.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// Stop filling the request queue once it holds about this many entries.
	localparam int unsigned REQUEST_TARGET = 1325;

	// This limit is many times the worst case of all transactions, even with both sides stalling.
	localparam int unsigned CYCLE_LIMIT = 300000;

	// Cycles to keep watching the output after the last expected result.
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [REQ_W-1:0]    kind;
		logic [SYMBOL_W-1:0] symbol;
		logic [LEN_W-1:0]    length;
	} code_request_s;

	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [LEN_W-1:0]    bits;
		logic                found;
		logic [STATUS_W-1:0] status;
	} code_result_s;

	logic clk = 1'b0;
	logic arst_n;

	hct_in_if  req_if ();
	hct_out_if res_if ();

	canonical_huffman_code_table_core #(
		.SYMBOL_COUNT   (TABLE_SYMBOLS),
		.MAX_CODE_LENGTH(MAX_LEN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (req_if),
		.out_ch(res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be driven, and the results predicted for requests that the
	// block has already accepted, oldest first.
	code_request_s request_queue[$];
	code_result_s  pending_codes[$];

	// Shadow copy of the code table that the predictor maintains.
	logic [CODE_W-1:0]  shadow_code [TABLE_SYMBOLS];
	logic [LEN_W-1:0]   shadow_len  [TABLE_SYMBOLS];
	logic [TABLE_SYMBOLS-1:0] shadow_valid;
	logic [NEXT_W-1:0]  run_code;
	logic [LEN_W-1:0]   run_len;

	int unsigned total_requests;
	int unsigned taken;      // request transactions accepted by the block
	int unsigned issued;     // requests placed on the bus by the driver
	int unsigned delivered;  // result transactions accepted by the testbench
	int unsigned mismatches;
	int unsigned cycle_count;

	// Driver and receiver bookkeeping; after setup each is written by its own block only.
	logic          in_busy;
	int unsigned   in_gap;
	code_request_s in_cur;
	int unsigned   out_seen;
	int unsigned   out_gap;

	function automatic void add_request(logic [REQ_W-1:0] kind, int unsigned sym,
		int unsigned len);
		code_request_s r;
		r.kind   = kind;
		r.symbol = sym[SYMBOL_W-1:0];
		r.length = len[LEN_W-1:0];
		request_queue.push_back(r);
	endfunction

	// Idle cycles before the next transaction on either side. Every fifth stretch of
	// one hundred transactions runs with no idling at all.
	function automatic int unsigned draw_gap(int unsigned n);
		if (((n / 100) % 5) == 4)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	// Canonical code assignment: the running code is shifted up by the growth in
	// length, handed to the symbol, and then incremented. A shifted code that reaches
	// 2^length means the code space of that length is used up.
	function automatic code_result_s predict_code_result(code_request_s r);
		code_result_s      res;
		logic [NEXT_W-1:0] shifted;
		logic [NEXT_W-1:0] limit;
		res = '0;
		case (r.kind)
			REQ_CLEAR: begin
				shadow_valid = '0;
				run_code     = '0;
				run_len      = '0;
			end
			REQ_APPEND: begin
				if (r.length == 0 || r.length > MAX_LEN || r.length < run_len) begin
					// Refused length: the table and the running code stay as they are.
					res.status = STATUS_ORDER;
				end else begin
					shifted = run_code << (r.length - run_len);
					run_len = r.length;
					limit   = NEXT_W'(1) << r.length;
					if (shifted >= limit) begin
						run_code   = limit;
						res.status = STATUS_FULL;
					end else begin
						run_code = shifted + 1'b1;
						res.code = shifted[CODE_W-1:0];
						res.bits = r.length;
						// A repeated symbol consumes its code but keeps the first entry.
						if (!shadow_valid[r.symbol]) begin
							shadow_code[r.symbol]  = shifted[CODE_W-1:0];
							shadow_len[r.symbol]   = r.length;
							shadow_valid[r.symbol] = 1'b1;
							res.found              = 1'b1;
						end
					end
				end
			end
			REQ_LOOKUP: begin
				if (shadow_valid[r.symbol]) begin
					res.code  = shadow_code[r.symbol];
					res.bits  = shadow_len[r.symbol];
					res.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Sample both channels at the rising edge. A request transaction is predicted
	// before the result side is checked, so the ordering holds for any latency.
	always @(posedge clk) begin : watch_channels
		code_request_s req;
		code_result_s  want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				req.kind   = req_if.req_type;
				req.symbol = req_if.symbol;
				req.length = req_if.code_length;
				pending_codes.push_back(predict_code_result(req));
				taken <= taken + 1;
			end
			if (res_if.valid && res_if.ready) begin
				if (pending_codes.size() == 0) begin
					$error("result transaction with no expected result waiting");
					mismatches++;
				end else begin
					want = pending_codes.pop_front();
					check_field("code", want.code, res_if.code);
					check_field("code_bits", want.bits, res_if.code_bits);
					check_field("found", want.found, res_if.found);
					check_field("status", want.status, res_if.status);
				end
				delivered <= delivered + 1;
			end
		end
	end

	// Request driver. An item stays on the bus until the rising edge shows it was
	// taken; then an idle gap is drawn. With a zero gap the next item follows at once,
	// so valid stays high without a drop in between.
	always @(negedge clk) begin : drive_requests
		if (arst_n) begin
			if (in_busy && taken == issued) begin
				in_busy = 1'b0;
				in_gap  = draw_gap(issued);
			end
			if (!in_busy) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (request_queue.size() > 0) begin
					in_cur  = request_queue.pop_front();
					in_busy = 1'b1;
					issued++;
				end
			end
			req_if.valid <= in_busy;
			if (in_busy) begin
				req_if.req_type    <= in_cur.kind;
				req_if.symbol      <= in_cur.symbol;
				req_if.code_length <= in_cur.length;
			end else begin
				// Idle payload is noise; the block must not look at it.
				req_if.req_type    <= REQ_W'($urandom);
				req_if.symbol      <= SYMBOL_W'($urandom);
				req_if.code_length <= LEN_W'($urandom);
			end
		end
	end

	// Result receiver. Ready is withheld for a drawn number of cycles before each
	// result and then held high until a result transaction goes through.
	always @(negedge clk) begin : accept_results
		logic rdy;
		if (arst_n) begin
			if (res_if.ready && delivered != out_seen) begin
				out_seen = delivered;
				out_gap  = draw_gap(out_seen);
			end
			rdy = 1'b0;
			if (out_gap > 0)
				out_gap--;
			else
				rdy = 1'b1;
			res_if.ready <= rdy;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : run_test
		int unsigned used[$];
		int unsigned len;
		int unsigned avail;
		int unsigned k;
		int unsigned placed;
		int unsigned target;
		int unsigned step;
		int unsigned sym;
		int unsigned n;

		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.req_type    = '0;
		req_if.symbol      = '0;
		req_if.code_length = '0;
		res_if.ready       = 1'b0;
		shadow_valid       = '0;
		run_code           = '0;
		run_len            = '0;
		taken              = 0;
		issued             = 0;
		delivered          = 0;
		mismatches         = 0;
		cycle_count        = 0;
		in_busy            = 1'b0;
		in_gap             = 0;
		in_cur             = '0;
		out_seen           = 0;
		out_gap            = 0;

		// Directed part. A lookup on the empty table right after reset misses.
		add_request(REQ_LOOKUP, 8'h00, 0);
		// Zero length, the largest field value, and one past the longest code are refused.
		add_request(REQ_APPEND, 8'hFF, 0);
		add_request(REQ_APPEND, 8'h00, 31);
		add_request(REQ_APPEND, 8'h00, MAX_LEN + 1);
		// First symbol gets code 0 of length 1.
		add_request(REQ_APPEND, 8'h00, 1);
		// The same symbol again takes code 10 but the first entry is kept.
		add_request(REQ_APPEND, 8'h00, 2);
		// A length shorter than the previous one is an order error.
		add_request(REQ_APPEND, 8'h55, 1);
		// Jump to the longest length: 11 shifted up to 16 bits.
		add_request(REQ_APPEND, 8'hAA, MAX_LEN);
		add_request(REQ_LOOKUP, 8'hAA, 31);
		add_request(REQ_LOOKUP, 8'h00, 0);
		add_request(REQ_LOOKUP, 8'h01, 0);
		// The unused request type changes nothing.
		add_request(REQ_UNUSED, 8'hFF, 31);
		add_request(REQ_LOOKUP, 8'hAA, 0);
		// Clear with nonzero fields, then the old entry is gone.
		add_request(REQ_CLEAR, 8'hFF, 31);
		add_request(REQ_LOOKUP, 8'hAA, 0);
		// Two codes of length 1 use up the whole code space, so longer ones are dropped.
		add_request(REQ_APPEND, 8'h10, 1);
		add_request(REQ_APPEND, 8'h20, 1);
		add_request(REQ_APPEND, 8'h30, MAX_LEN);
		add_request(REQ_APPEND, 8'h30, MAX_LEN);
		add_request(REQ_LOOKUP, 8'h30, 0);
		add_request(REQ_LOOKUP, 8'h20, 0);
		add_request(REQ_CLEAR, 8'h00, 0);
		add_request(REQ_APPEND, 8'hFF, MAX_LEN);
		add_request(REQ_LOOKUP, 8'hFF, 0);

		// Random part: mostly well-formed tables with nondecreasing lengths, each followed
		// by lookups, with refused lengths, unused requests and stray lookups mixed in.
		while (request_queue.size() < REQUEST_TARGET) begin
			used.delete();
			if ($urandom_range(0, 9) != 0)
				add_request(REQ_CLEAR, $urandom, $urandom);
			len    = $urandom_range(1, 4);
			avail  = 1 << len;
			target = $urandom_range(3, 40);
			while (len <= MAX_LEN && target > 0) begin
				// A nearly full level keeps the free code space small, which drives the
				// codes toward all ones at the longer lengths.
				if (avail <= 4)
					k = ($urandom_range(0, 7) != 0) ? avail - 1 : avail;
				else
					k = $urandom_range(0, 3);
				placed = 0;
				while (placed < k && target > 0) begin
					if ($urandom_range(0, 11) == 0) begin
						case ($urandom_range(0, 4))
							0: add_request(REQ_APPEND, $urandom, 0);
							1: add_request(REQ_APPEND, $urandom, $urandom_range(MAX_LEN + 1, 31));
							2: add_request(REQ_APPEND, $urandom, (len > 1) ? $urandom_range(1, len - 1) : 0);
							3: add_request(REQ_UNUSED, $urandom, $urandom);
							default: add_request(REQ_LOOKUP, $urandom, $urandom);
						endcase
					end
					if (used.size() > 0 && $urandom_range(0, 7) == 0)
						sym = used[$urandom_range(0, used.size() - 1)];
					else
						sym = $urandom_range(0, 255);
					used.push_back(sym);
					add_request(REQ_APPEND, sym, len);
					placed++;
					target--;
				end
				avail -= placed;
				if (avail == 0) begin
					// Code space used up: further appends are dropped.
					repeat ($urandom_range(1, 2))
						add_request(REQ_APPEND, $urandom, $urandom_range(len, MAX_LEN));
					break;
				end
				step  = ($urandom_range(0, 3) == 0) ? 2 : 1;
				avail = avail << step;
				len   = len + step;
			end
			n = $urandom_range(4, 16);
			repeat (n) begin
				if (used.size() > 0 && $urandom_range(0, 3) != 0)
					sym = used[$urandom_range(0, used.size() - 1)];
				else
					sym = $urandom_range(0, 255);
				add_request(REQ_LOOKUP, sym, $urandom);
			end
		end
		total_requests = request_queue.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request transaction and its result, then watch for strays.
		while (!(taken == total_requests && pending_codes.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
